[rtl/pitl_pkg.sv]
// Shared types, constants and tables of the pre-integration table lookup block.
`timescale 1ns / 1ps

package pitl_pkg;

    localparam int SAMPLES   = 256;
    localparam int IDX_W     = $clog2(SAMPLES);
    localparam int CH_W      = 16;
    localparam int SUM_W     = 24;
    localparam int SMP_W     = 4 * CH_W;
    localparam int PRE_W     = 2 * SUM_W;
    localparam int STEP_W    = 20;
    localparam int BAND_W    = 9;
    localparam int CFG_IDX_W = 3;

    localparam logic [16:0] ONE_Q16    = 17'h10000;
    localparam logic [24:0] LOG2E_Q24  = 25'd24204406;
    localparam logic [21:0] STOP_LEVEL = 22'd1245184;
    localparam logic [31:0] EXP_ONE    = 32'h8000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_MODE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_START    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_END      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_EXPONENT = 3'd4;

    localparam logic [1:0] ALPHA_KEEP = 2'd0;
    localparam logic [1:0] ALPHA_FULL = 2'd1;
    localparam logic [1:0] ALPHA_ZERO = 2'd2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] sample_index;
        logic [CH_W-1:0]  sample_red;
        logic [CH_W-1:0]  sample_green;
        logic [CH_W-1:0]  sample_blue;
        logic [CH_W-1:0]  sample_alpha;
        logic [IDX_W-1:0] front_index;
        logic [IDX_W-1:0] back_index;
    } pitl_item_t;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_alpha;
    } pitl_result_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_QUERY,
        ST_EQ_DATA,
        ST_W_CHECK,
        ST_W_DATA,
        ST_W_ACC1,
        ST_W_ACC2,
        ST_W_ADV,
        ST_I_HI,
        ST_I_LO,
        ST_I_MUL,
        ST_I_Y1,
        ST_I_Y2,
        ST_LOG_NORM,
        ST_LOG_SQ,
        ST_Z_MUL,
        ST_DIV,
        ST_EXP,
        ST_EXP_FIN,
        ST_NORM_INIT,
        ST_NORM,
        ST_OUT
    } pitl_state_t;

    // Successive square roots of one half in Q31, each floored.
    function automatic logic [16:0][31:0] build_roots();
        logic [16:0][31:0] tab;
        logic [63:0]       v;
        logic [63:0]       res;
        logic [63:0]       bt;
        tab    = '0;
        tab[0] = 32'h4000_0000;
        for (int k = 1; k <= 16; k++)
        begin
            v   = {1'b0, tab[k-1], 31'd0};
            res = '0;
            bt  = 64'h4000_0000_0000_0000;
            for (int j = 0; j < 32; j++)
            begin
                if (v >= res + bt)
                begin
                    v   = v - (res + bt);
                    res = (res >> 1) + bt;
                end
                else
                begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
            tab[k] = res[31:0];
        end
        return tab;
    endfunction

    localparam logic [16:0][31:0] ROOT_TAB = build_roots();

endpackage

[rtl/preintegration_table_lookup.sv]
// Top level of the pre-integration table lookup: sample loading, segment queries and control.
`timescale 1ns / 1ps

// A load word gives no result. A query word gives one result word, shown for one cycle on
// result with done high, which must be taken as it comes. Every opacity correction runs
// through one shared iterative unit: 16 squaring steps for the logarithm, 36 divider steps
// and 16 steps of the power of two. A compositing walk runs that correction only for visited
// samples with nonzero opacity and passes over transparent ones. The sample and prefix stores
// sit in three RAMs of 256 words; their contents are undefined until loaded.
module preintegration_table_lookup (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  pitl_pkg::pitl_item_t            item,
    output logic                            done,
    output pitl_pkg::pitl_result_t          result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pitl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pitl_pkg::STEP_W-1:0]     cfg_data
);

    import pitl_pkg::*;

    pitl_state_t             state_reg, state_next;
    pitl_item_t              item_reg, item_next;
    logic                    integral_mode_reg;
    logic [1:0]              alpha_mode_reg;
    logic [BAND_W-1:0]       band_start_reg;
    logic [BAND_W-1:0]       band_end_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [PRE_W-1:0]        run_rg_reg, run_rg_next;
    logic [PRE_W-1:0]        run_ba_reg, run_ba_next;
    logic                    done_reg, done_next;
    pitl_result_t            result_reg, result_next;

    logic [IDX_W-1:0]        s_reg, s_next;
    logic                    eq_reg, eq_next;
    logic                    int_reg, int_next;
    logic [SMP_W-1:0]        smp_reg, smp_next;
    logic [16:0]             m_reg, m_next;
    logic [4:0]              n_reg, n_next;
    logic [15:0]             frac_reg, frac_next;
    logic [5:0]              cnt_reg, cnt_next;
    logic [8:0]              div_d_reg, div_d_next;
    logic [3:0][35:0]        dq_reg, dq_next;
    logic [3:0][8:0]         drem_reg, drem_next;
    logic [36:0]             y_reg, y_next;
    logic [31:0]             er_reg, er_next;
    logic [16:0]             ca_reg, ca_next;
    logic [16:0]             w_reg, w_next;
    logic [2:0][35:0]        acc_reg, acc_next;
    logic [16:0]             acc_a_reg, acc_a_next;
    logic [PRE_W-1:0]        hi_rg_reg, hi_rg_next;
    logic [PRE_W-1:0]        hi_ba_reg, hi_ba_next;
    logic [3:0][23:0]        dif_reg, dif_next;
    logic [42:0]             plo_reg, plo_next;
    logic [2:0][16:0]        nrem_reg, nrem_next;
    logic [2:0][15:0]        nq_reg, nq_next;
    logic [2:0][15:0]        nfix_reg, nfix_next;
    logic [2:0]              nuse_reg, nuse_next;

    logic [SMP_W-1:0]        smp_rdata;
    logic [PRE_W-1:0]        prg_rdata;
    logic [PRE_W-1:0]        pba_rdata;
    logic [IDX_W-1:0]        smp_raddr;
    logic [IDX_W-1:0]        pre_raddr;
    logic                    ram_we;
    logic [SMP_W-1:0]        smp_wdata;

    logic [IDX_W-1:0]        q_front, q_back, q_lo, q_hi, q_span;
    logic                    in_band;
    logic [CH_W-1:0]         ld_r, ld_g, ld_b, ld_a;
    logic [31:0]             pr_r, pr_g, pr_b;
    logic [PRE_W-1:0]        base_rg, base_ba, new_rg, new_ba;

    logic [16:0]             t_val;
    logic [4:0]              t_pos;
    logic [4:0]              t_shift;
    logic [33:0]             sq;
    logic [17:0]             m2;
    logic [20:0]             nl;
    logic [40:0]             zprod;
    logic [3:0][9:0]         rem2;
    logic [3:0]              dge;
    logic [3:0][35:0]        dq_step;
    logic [3:0][8:0]         drem_step;
    logic [3:0]              cnt_lo;
    logic [63:0]             emul;
    logic [20:0]             ip;
    logic [5:0]              esh;
    logic [31:0]             e_full;
    logic [16:0]             e_val, o_val;
    logic [33:0]             wmul;
    logic [2:0][32:0]        cmul;
    logic [21:0]             stop_prod;
    logic                    stop;
    logic [3:0][43:0]        xmul;
    logic [42:0]             phi;
    logic [60:0]             yfull;
    logic                    nsmall;
    logic [2:0][17:0]        nrem2;
    logic [2:0]              nge;
    logic [2:0][16:0]        nprod;

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    assign q_front = item_reg.front_index;
    assign q_back  = item_reg.back_index;
    assign q_lo    = (q_front < q_back) ? q_front : q_back;
    assign q_hi    = (q_front < q_back) ? q_back : q_front;
    assign q_span  = q_hi - q_lo;

    // Sample load
    assign in_band = ({1'b0, item_reg.sample_index} >= band_start_reg)
                  && ({1'b0, item_reg.sample_index} < band_end_reg);
    assign ld_r = in_band ? item_reg.sample_red   : '0;
    assign ld_g = in_band ? item_reg.sample_green : '0;
    assign ld_b = in_band ? item_reg.sample_blue  : '0;

    always_comb
    begin
        ld_a = in_band ? item_reg.sample_alpha : '0;
        if (alpha_mode_reg == ALPHA_FULL && ld_a != '0)
        begin
            ld_a = 16'hFFFF;
        end
        else if (alpha_mode_reg == ALPHA_ZERO)
        begin
            ld_a = '0;
        end
    end

    assign pr_r    = ld_r * ld_a;
    assign pr_g    = ld_g * ld_a;
    assign pr_b    = ld_b * ld_a;
    assign base_rg = (item_reg.sample_index == '0) ? '0 : run_rg_reg;
    assign base_ba = (item_reg.sample_index == '0) ? '0 : run_ba_reg;

    always_comb
    begin
        new_rg = base_rg;
        new_ba = base_ba;
        if (ld_a != '0)
        begin
            new_rg = {base_rg[47:24] + {8'd0, pr_g[31:16]},
                      base_rg[23:0] + {8'd0, pr_r[31:16]}};
            new_ba = {base_ba[47:24] + {8'd0, ld_a},
                      base_ba[23:0] + {8'd0, pr_b[31:16]}};
        end
    end

    assign smp_wdata = {ld_a, ld_b, ld_g, ld_r};
    assign ram_we    = (state_reg == ST_LOAD);
    assign smp_raddr = (state_reg == ST_QUERY) ? q_front : s_reg;
    assign pre_raddr = (state_reg == ST_QUERY) ? q_hi : q_lo;

    pitl_ram #(.WIDTH(SMP_W), .DEPTH(SAMPLES)) u_sample_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (item_reg.sample_index),
        .wdata (smp_wdata),
        .raddr (smp_raddr),
        .rdata (smp_rdata)
    );

    pitl_ram #(.WIDTH(PRE_W), .DEPTH(SAMPLES)) u_prefix_rg_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (item_reg.sample_index),
        .wdata (new_rg),
        .raddr (pre_raddr),
        .rdata (prg_rdata)
    );

    pitl_ram #(.WIDTH(PRE_W), .DEPTH(SAMPLES)) u_prefix_ba_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (item_reg.sample_index),
        .wdata (new_ba),
        .raddr (pre_raddr),
        .rdata (pba_rdata)
    );

    // Logarithm unit
    assign t_val = ONE_Q16 - {1'b0, smp_reg[63:48]};

    always_comb
    begin
        t_pos = '0;
        for (int i = 0; i < 17; i++)
        begin
            if (t_val[i])
            begin
                t_pos = 5'(i);
            end
        end
    end

    assign t_shift = 5'd16 - t_pos;
    assign sq      = m_reg * m_reg;
    assign m2      = sq[33:16];
    assign nl      = {n_reg, 16'd0} - {5'd0, frac_reg};
    assign zprod   = nl * step_reg;

    // Four-lane restoring divider with a shared divisor
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            rem2[k]      = {drem_reg[k], dq_reg[k][35]};
            dge[k]       = (rem2[k] >= {1'b0, div_d_reg});
            drem_step[k] = dge[k] ? 9'(rem2[k] - {1'b0, div_d_reg}) : rem2[k][8:0];
            dq_step[k]   = {dq_reg[k][34:0], dge[k]};
        end
    end

    // Power-of-two unit
    assign cnt_lo = cnt_reg[3:0];
    assign emul   = er_reg * ROOT_TAB[5'({1'b0, cnt_lo} + 5'd1)];
    assign ip     = y_reg[36:16];
    assign esh    = 6'd15 + {1'b0, ip[4:0]};
    assign e_full = er_reg >> esh;
    assign e_val  = (ip >= 21'd17) ? '0 : e_full[16:0];
    assign o_val  = ONE_Q16 - e_val;

    // Compositing
    assign wmul      = (ONE_Q16 - acc_a_reg) * ca_reg;
    assign stop_prod = acc_a_reg * 5'd20;
    assign stop      = (stop_prod >= STOP_LEVEL);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cmul[k] = w_reg * smp_reg[16*k +: 16];
        end
    end

    // Integral approximation
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            xmul[k] = dif_reg[k] * step_reg;
        end
    end

    assign phi   = dq_reg[3][35:18] * LOG2E_Q24;
    assign yfull = {phi, 18'd0} + {18'd0, plo_reg};

    // Colour normalisation
    assign nsmall = (acc_a_reg < 17'd66);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            nrem2[k] = {nrem_reg[k], 1'b0};
            nge[k]   = (nrem2[k] >= {1'b0, acc_a_reg});
            nprod[k] = acc_reg[k][6:0] * 10'd1000;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        run_rg_next = run_rg_reg;
        run_ba_next = run_ba_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        s_next      = s_reg;
        eq_next     = eq_reg;
        int_next    = int_reg;
        smp_next    = smp_reg;
        m_next      = m_reg;
        n_next      = n_reg;
        frac_next   = frac_reg;
        cnt_next    = cnt_reg;
        div_d_next  = div_d_reg;
        dq_next     = dq_reg;
        drem_next   = drem_reg;
        y_next      = y_reg;
        er_next     = er_reg;
        ca_next     = ca_reg;
        w_next      = w_reg;
        acc_next    = acc_reg;
        acc_a_next  = acc_a_reg;
        hi_rg_next  = hi_rg_reg;
        hi_ba_next  = hi_ba_reg;
        dif_next    = dif_reg;
        plo_next    = plo_reg;
        nrem_next   = nrem_reg;
        nq_next     = nq_reg;
        nfix_next   = nfix_reg;
        nuse_next   = nuse_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    state_next = (item.cmd == CMD_LOAD) ? ST_LOAD : ST_QUERY;
                end
            end
            ST_LOAD:
            begin
                run_rg_next = new_rg;
                run_ba_next = new_ba;
                state_next  = ST_IDLE;
            end
            ST_QUERY:
            begin
                if (q_front == q_back)
                begin
                    eq_next    = 1'b1;
                    int_next   = 1'b0;
                    div_d_next = 9'd1;
                    state_next = ST_EQ_DATA;
                end
                else if (integral_mode_reg)
                begin
                    eq_next    = 1'b0;
                    int_next   = 1'b1;
                    div_d_next = {1'b0, q_span};
                    state_next = ST_I_HI;
                end
                else
                begin
                    eq_next    = 1'b0;
                    int_next   = 1'b0;
                    div_d_next = {1'b0, q_span} + 9'd1;
                    s_next     = q_front;
                    acc_next   = '0;
                    acc_a_next = '0;
                    state_next = ST_W_CHECK;
                end
            end
            ST_EQ_DATA:
            begin
                smp_next   = smp_rdata;
                state_next = ST_LOG_NORM;
            end
            ST_LOG_NORM:
            begin
                m_next     = t_val << t_shift;
                n_next     = t_shift;
                frac_next  = '0;
                cnt_next   = '0;
                state_next = ST_LOG_SQ;
            end
            ST_LOG_SQ:
            begin
                if (m2[17])
                begin
                    m_next    = m2[17:1];
                    frac_next = {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    m_next    = m2[16:0];
                    frac_next = {frac_reg[14:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd15)
                begin
                    cnt_next   = '0;
                    state_next = ST_Z_MUL;
                end
            end
            ST_Z_MUL:
            begin
                dq_next[0] = {3'd0, zprod[40:8]};
                drem_next  = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                dq_next   = dq_step;
                drem_next = drem_step;
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'd35)
                begin
                    cnt_next = '0;
                    if (int_reg)
                    begin
                        state_next = ST_I_Y1;
                    end
                    else
                    begin
                        y_next     = {1'b0, dq_step[0]};
                        er_next    = EXP_ONE;
                        state_next = ST_EXP;
                    end
                end
            end
            ST_EXP:
            begin
                if (y_reg[~cnt_lo])
                begin
                    er_next = emul[62:31];
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd15)
                begin
                    cnt_next   = '0;
                    state_next = ST_EXP_FIN;
                end
            end
            ST_EXP_FIN:
            begin
                if (int_reg)
                begin
                    acc_a_next = o_val;
                    state_next = ST_NORM_INIT;
                end
                else if (eq_reg)
                begin
                    result_next.out_red   = smp_reg[15:0];
                    result_next.out_green = smp_reg[31:16];
                    result_next.out_blue  = smp_reg[47:32];
                    result_next.out_alpha = o_val[16] ? 16'hFFFF : o_val[15:0];
                    done_next             = 1'b1;
                    state_next            = ST_IDLE;
                end
                else
                begin
                    ca_next    = o_val;
                    state_next = ST_W_ACC1;
                end
            end
            ST_W_CHECK:
            begin
                state_next = stop ? ST_NORM_INIT : ST_W_DATA;
            end
            ST_W_DATA:
            begin
                smp_next   = smp_rdata;
                state_next = (smp_rdata[63:48] != '0) ? ST_LOG_NORM : ST_W_ADV;
            end
            ST_W_ACC1:
            begin
                w_next     = wmul[32:16];
                state_next = ST_W_ACC2;
            end
            ST_W_ACC2:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    acc_next[k] = acc_reg[k] + {19'd0, cmul[k][32:16]};
                end
                acc_a_next = acc_a_reg + w_reg;
                state_next = ST_W_ADV;
            end
            ST_W_ADV:
            begin
                if (s_reg == q_back)
                begin
                    state_next = ST_NORM_INIT;
                end
                else
                begin
                    s_next     = (q_front < q_back) ? s_reg + 8'd1 : s_reg - 8'd1;
                    state_next = ST_W_CHECK;
                end
            end
            ST_I_HI:
            begin
                hi_rg_next = prg_rdata;
                hi_ba_next = pba_rdata;
                state_next = ST_I_LO;
            end
            ST_I_LO:
            begin
                dif_next[0] = hi_rg_reg[23:0] - prg_rdata[23:0];
                dif_next[1] = hi_rg_reg[47:24] - prg_rdata[47:24];
                dif_next[2] = hi_ba_reg[23:0] - pba_rdata[23:0];
                dif_next[3] = hi_ba_reg[47:24] - pba_rdata[47:24];
                state_next  = ST_I_MUL;
            end
            ST_I_MUL:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    dq_next[k] = xmul[k][43:8];
                end
                drem_next  = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_I_Y1:
            begin
                plo_next   = dq_reg[3][17:0] * LOG2E_Q24;
                for (int k = 0; k < 3; k++)
                begin
                    acc_next[k] = dq_reg[k];
                end
                state_next = ST_I_Y2;
            end
            ST_I_Y2:
            begin
                y_next     = yfull[60:24];
                er_next    = EXP_ONE;
                cnt_next   = '0;
                state_next = ST_EXP;
            end
            ST_NORM_INIT:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    nq_next[k]   = '0;
                    nrem_next[k] = acc_reg[k][16:0];
                    if (nsmall)
                    begin
                        nuse_next[k] = 1'b1;
                        nfix_next[k] = (acc_reg[k] >= 36'd66) ? 16'hFFFF : nprod[k][15:0];
                    end
                    else if (acc_reg[k] >= {19'd0, acc_a_reg})
                    begin
                        nuse_next[k] = 1'b1;
                        nfix_next[k] = 16'hFFFF;
                    end
                    else
                    begin
                        nuse_next[k] = 1'b0;
                        nfix_next[k] = '0;
                    end
                end
                cnt_next   = '0;
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    nrem_next[k] = nge[k] ? 17'(nrem2[k] - {1'b0, acc_a_reg})
                                          : nrem2[k][16:0];
                    nq_next[k]   = {nq_reg[k][14:0], nge[k]};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd15)
                begin
                    cnt_next   = '0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                result_next.out_red   = nuse_reg[0] ? nfix_reg[0] : nq_reg[0];
                result_next.out_green = nuse_reg[1] ? nfix_reg[1] : nq_reg[1];
                result_next.out_blue  = nuse_reg[2] ? nfix_reg[2] : nq_reg[2];
                result_next.out_alpha = acc_a_reg[16] ? 16'hFFFF : acc_a_reg[15:0];
                done_next             = 1'b1;
                state_next            = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            done_reg   <= 1'b0;
            run_rg_reg <= '0;
            run_ba_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            run_rg_reg <= run_rg_next;
            run_ba_reg <= run_ba_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_mode_reg <= 1'b0;
            alpha_mode_reg    <= ALPHA_KEEP;
            band_start_reg    <= '0;
            band_end_reg      <= 9'd256;
            step_reg          <= 20'd51200;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_INTEGRAL_MODE: integral_mode_reg <= cfg_data[0];
                CFG_ALPHA_MODE:    alpha_mode_reg    <= cfg_data[1:0];
                CFG_BAND_START:    band_start_reg    <= cfg_data[BAND_W-1:0];
                CFG_BAND_END:      band_end_reg      <= cfg_data[BAND_W-1:0];
                CFG_STEP_EXPONENT: step_reg          <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
        s_reg      <= s_next;
        eq_reg     <= eq_next;
        int_reg    <= int_next;
        smp_reg    <= smp_next;
        m_reg      <= m_next;
        n_reg      <= n_next;
        frac_reg   <= frac_next;
        cnt_reg    <= cnt_next;
        div_d_reg  <= div_d_next;
        dq_reg     <= dq_next;
        drem_reg   <= drem_next;
        y_reg      <= y_next;
        er_reg     <= er_next;
        ca_reg     <= ca_next;
        w_reg      <= w_next;
        acc_reg    <= acc_next;
        acc_a_reg  <= acc_a_next;
        hi_rg_reg  <= hi_rg_next;
        hi_ba_reg  <= hi_ba_next;
        dif_reg    <= dif_next;
        plo_reg    <= plo_next;
        nrem_reg   <= nrem_next;
        nq_reg     <= nq_next;
        nfix_reg   <= nfix_next;
        nuse_reg   <= nuse_next;
    end

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result word without a query in progress");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |=> !done)
        else $error("load word produced a result");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_d_reg != '0))
        else $error("divider started with a zero divisor");

    a_alpha_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_W_ADV) |-> (acc_a_reg <= ONE_Q16))
        else $error("accumulated opacity exceeds one");

endmodule

[rtl/pitl_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module pitl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[verif/tb.sv]
// Self-checking testbench for the pre-integration table lookup: directed table, then random phases.
`timescale 1ns / 1ps

module tb;
    import pitl_pkg::*;

    localparam int WATCHDOG_LIMIT = 100000;

    typedef struct {
        pitl_item_t   it;
        bit           typed;
        pitl_result_t res;
    } row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    pitl_item_t           item;
    logic                 done;
    pitl_result_t         result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [STEP_W-1:0]    cfg_data;

    logic [63:0] sample_mem [SAMPLES];
    logic [47:0] prefix_rg [SAMPLES];
    logic [47:0] prefix_ba [SAMPLES];
    logic [47:0] sum_rg;
    logic [47:0] sum_ba;
    logic [63:0] root_q31 [17];
    logic        mode_integral;
    logic [1:0]  mode_alpha;
    logic [8:0]  keep_lo;
    logic [8:0]  keep_hi;
    logic [19:0] step_exp;

    pitl_result_t pending_colours [$];
    int           mismatches;
    int           idle_cycles;
    int           items_sent;
    int           filled;
    bit           no_gaps;
    row_t         rows [$];

    preintegration_table_lookup dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bt;
        res = 64'd0;
        bt  = 64'd1 << 62;
        while (bt > v)
            bt = bt >> 2;
        while (bt != 0)
        begin
            if (v >= res + bt)
            begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end
            else
            begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] neg_log2(logic [63:0] t);
        logic [63:0] m;
        logic [63:0] frac;
        logic [63:0] n;
        m    = t;
        frac = 64'd0;
        n    = 64'd0;
        while (m < 64'd65536)
        begin
            m = m << 1;
            n = n + 1;
        end
        for (int i = 0; i < 16; i++)
        begin
            m    = (m * m) >> 16;
            frac = frac << 1;
            if (m >= 64'd131072)
            begin
                m    = m >> 1;
                frac = frac | 64'd1;
            end
        end
        return (n << 16) - frac;
    endfunction

    function automatic logic [63:0] pow2_neg(logic [63:0] y);
        logic [63:0] ip;
        logic [63:0] frac;
        logic [63:0] r;
        ip   = y >> 16;
        frac = y & 64'hFFFF;
        r    = 64'd1 << 31;
        if (ip >= 32)
            return 64'd0;
        for (int k = 1; k <= 16; k++)
            if (frac[16-k])
                r = (r * root_q31[k]) >> 31;
        return r >> (15 + ip);
    endfunction

    function automatic logic [63:0] corrected_alpha(logic [63:0] a16, logic [63:0] num,
                                                    logic [63:0] den);
        logic [63:0] t16;
        logic [63:0] z;
        t16 = (a16 >= 64'd65536) ? 64'd0 : 64'd65536 - a16;
        if (t16 == 0)
            return (num != 0) ? 64'd65536 : 64'd0;
        z = neg_log2(t16) * num / den;
        return 64'd65536 - pow2_neg(z);
    endfunction

    function automatic logic [15:0] clamp16(logic [63:0] v);
        return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [15:0] unpremultiply(logic [63:0] c, logic [63:0] a);
        if (a * 1000 < 64'd65536)
            return clamp16(c * 1000);
        return clamp16((c << 16) / a);
    endfunction

    function automatic logic [63:0] chan(logic [63:0] s, int k);
        return (s >> (16 * k)) & 64'hFFFF;
    endfunction

    function automatic logic [63:0] sum_diff(logic [23:0] hi, logic [23:0] lo);
        logic [23:0] d;
        d = hi - lo;
        return {40'd0, d};
    endfunction

    function automatic pitl_result_t segment_colour(int f, int b);
        pitl_result_t o;
        logic [63:0]  r, g, bl, a, den, ca, w, xa, y, smp;
        int           lo, hi, s;
        if (f == b)
        begin
            smp         = sample_mem[f];
            o.out_red   = 16'(chan(smp, 0));
            o.out_green = 16'(chan(smp, 1));
            o.out_blue  = 16'(chan(smp, 2));
            o.out_alpha = clamp16(corrected_alpha(chan(smp, 3), step_exp, 64'd256));
            return o;
        end
        if (mode_integral)
        begin
            lo  = (f < b) ? f : b;
            hi  = (f < b) ? b : f;
            den = 64'd256 * (hi - lo);
            r   = sum_diff(prefix_rg[hi][23:0], prefix_rg[lo][23:0]) * step_exp / den;
            g   = sum_diff(prefix_rg[hi][47:24], prefix_rg[lo][47:24]) * step_exp / den;
            bl  = sum_diff(prefix_ba[hi][23:0], prefix_ba[lo][23:0]) * step_exp / den;
            xa  = sum_diff(prefix_ba[hi][47:24], prefix_ba[lo][47:24]) * step_exp / den;
            if (xa >= (64'd1 << 36))
            begin
                a = 64'd65536;
            end
            else
            begin
                y = (xa * 64'd24204406) >> 24;
                a = 64'd65536 - pow2_neg(y);
            end
        end
        else
        begin
            den = 64'd256 * (((f < b) ? b - f : f - b) + 1);
            s   = f;
            r   = 0;
            g   = 0;
            bl  = 0;
            a   = 0;
            forever
            begin
                if (a * 20 >= 64'd19 * 65536)
                    break;
                smp = sample_mem[s];
                if (chan(smp, 3) > 0)
                begin
                    ca = corrected_alpha(chan(smp, 3), step_exp, den);
                    w  = ((64'd65536 - a) * ca) >> 16;
                    r  = r + ((w * chan(smp, 0)) >> 16);
                    g  = g + ((w * chan(smp, 1)) >> 16);
                    bl = bl + ((w * chan(smp, 2)) >> 16);
                    a  = a + w;
                end
                if (s == b)
                    break;
                s = (f < b) ? s + 1 : s - 1;
            end
        end
        o.out_red   = unpremultiply(r, a);
        o.out_green = unpremultiply(g, a);
        o.out_blue  = unpremultiply(bl, a);
        o.out_alpha = clamp16(a);
        return o;
    endfunction

    task automatic store_sample(pitl_item_t it);
        logic [63:0] r, g, b, a;
        int          i;
        i = it.sample_index;
        r = 0;
        g = 0;
        b = 0;
        a = 0;
        if (i >= keep_lo && i < keep_hi)
        begin
            r = it.sample_red;
            g = it.sample_green;
            b = it.sample_blue;
            a = it.sample_alpha;
            if (mode_alpha == ALPHA_FULL && a != 0)
                a = 64'hFFFF;
            else if (mode_alpha == ALPHA_ZERO)
                a = 0;
        end
        sample_mem[i] = r | (g << 16) | (b << 32) | (a << 48);
        if (i == 0)
        begin
            sum_rg = '0;
            sum_ba = '0;
        end
        if (a > 0)
        begin
            sum_rg[23:0]  = sum_rg[23:0] + 24'((r * a) >> 16);
            sum_rg[47:24] = sum_rg[47:24] + 24'((g * a) >> 16);
            sum_ba[23:0]  = sum_ba[23:0] + 24'((b * a) >> 16);
            sum_ba[47:24] = sum_ba[47:24] + 24'(a);
        end
        prefix_rg[i] = sum_rg;
        prefix_ba[i] = sum_ba;
    endtask

    task automatic send_word(pitl_item_t it, bit typed, pitl_result_t typed_res);
        bit taken;
        start <= 1'b1;
        item  <= it;
        forever
        begin
            taken = !busy;
            @(posedge clk);
            if (taken)
                break;
            @(negedge clk);
        end
        items_sent++;
        if (it.cmd == CMD_LOAD)
            store_sample(it);
        else if (typed)
            pending_colours.push_back(typed_res);
        else
            pending_colours.push_back(segment_colour(it.front_index, it.back_index));
        @(negedge clk);
    endtask

    task automatic idle_gap();
        int p;
        int gap;
        p   = $urandom_range(0, 99);
        gap = 0;
        if (!no_gaps)
        begin
            if (p >= 90)
                gap = $urandom_range(10, 60);
            else if (p >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] val);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        forever
        begin
            taken = cfg_ready;
            @(posedge clk);
            if (taken)
                break;
            @(negedge clk);
        end
        case (idx)
            CFG_INTEGRAL_MODE: mode_integral = val[0];
            CFG_ALPHA_MODE:    mode_alpha    = val[1:0];
            CFG_BAND_START:    keep_lo       = val[8:0];
            CFG_BAND_END:      keep_hi       = val[8:0];
            CFG_STEP_EXPONENT: step_exp      = val;
            default:           ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_colours.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        while (busy)
            @(negedge clk);
    endtask

    function automatic pitl_item_t random_word();
        pitl_item_t  it;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        it  = raw[$bits(pitl_item_t)-1:0];
        return it;
    endfunction

    function automatic logic [15:0] random_alpha();
        int p;
        p = $urandom_range(0, 99);
        if (p < 25)
            return 16'd0;
        if (p < 35)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    function automatic pitl_item_t load_word(int i, int r, int g, int b, int a);
        pitl_item_t it;
        it              = '0;
        it.cmd          = CMD_LOAD;
        it.sample_index = IDX_W'(i);
        it.sample_red   = CH_W'(r);
        it.sample_green = CH_W'(g);
        it.sample_blue  = CH_W'(b);
        it.sample_alpha = CH_W'(a);
        return it;
    endfunction

    function automatic pitl_item_t query_word(int f, int b);
        pitl_item_t it;
        it             = '0;
        it.cmd         = CMD_QUERY;
        it.front_index = IDX_W'(f);
        it.back_index  = IDX_W'(b);
        return it;
    endfunction

    task automatic add_row(pitl_item_t it, bit typed, pitl_result_t res);
        row_t rw;
        rw.it    = it;
        rw.typed = typed;
        rw.res   = res;
        rows.push_back(rw);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb failed");
                $finish;
            end
            if (done)
            begin
                if (pending_colours.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word %h", result);
                end
                else
                begin
                    if (result !== pending_colours[0])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected r %h g %h b %h a %h, got r %h g %h b %h a %h",
                                     pending_colours[0].out_red, pending_colours[0].out_green,
                                     pending_colours[0].out_blue, pending_colours[0].out_alpha,
                                     result.out_red, result.out_green, result.out_blue,
                                     result.out_alpha);
                    end
                    void'(pending_colours.pop_front());
                end
            end
        end
    end

    initial
    begin
        pitl_result_t none;
        pitl_result_t res;
        pitl_item_t   it;
        int           f, b, n, nq, phase;
        int           ext_im [8];
        int           ext_am [8];
        int           ext_bs [8];
        int           ext_be [8];
        int           ext_st [8];

        ext_im        = '{0, 1, 0, 1, 0, 1, 0, 1};
        ext_am        = '{0, 1, 2, 3, 0, 0, 1, 0};
        ext_bs        = '{0, 0, 0, 0, 256, 100, 0, 0};
        ext_be        = '{256, 256, 256, 256, 0, 50, 256, 256};
        ext_st        = '{1, 1048575, 51200, 200, 51200, 0, 0, 1048575};
        none          = '0;
        mismatches    = 0;
        idle_cycles   = 0;
        items_sent    = 0;
        no_gaps       = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        item          = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        mode_integral = 1'b0;
        mode_alpha    = ALPHA_KEEP;
        keep_lo       = 9'd0;
        keep_hi       = 9'd256;
        step_exp      = 20'd51200;
        sum_rg        = '0;
        sum_ba        = '0;
        root_q31[0]   = 64'd1 << 30;
        for (int k = 1; k <= 16; k++)
            root_q31[k] = int_sqrt(root_q31[k-1] << 31);
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        res = '{16'd1234, 16'd5, 16'hFFFF, 16'd0};
        add_row(load_word(0, 1234, 5, 65535, 0), 0, none);
        add_row(load_word(1, 65535, 65535, 65535, 65535), 0, none);
        add_row(load_word(2, 0, 0, 0, 1), 0, none);
        add_row(load_word(3, 40000, 20000, 10000, 30000), 0, none);
        add_row(load_word(4, 65535, 0, 65535, 100), 0, none);
        add_row(load_word(5, 0, 65535, 0, 65535), 0, none);
        add_row(load_word(6, 12345, 54321, 777, 0), 0, none);
        add_row(load_word(7, 30000, 30000, 30000, 60000), 0, none);
        add_row(query_word(0, 0), 1, res);
        add_row(query_word(1, 1), 0, none);
        add_row(query_word(2, 2), 0, none);
        add_row(query_word(0, 7), 0, none);
        add_row(query_word(7, 0), 0, none);
        add_row(query_word(3, 5), 0, none);
        add_row(query_word(1, 0), 0, none);
        add_row(query_word(6, 6), 0, none);
        foreach (rows[i])
            send_word(rows[i].it, rows[i].typed, rows[i].res);
        drain();

        phase = 0;
        while (items_sent < 1100)
        begin
            if (phase < 8)
            begin
                write_reg(CFG_INTEGRAL_MODE, STEP_W'(ext_im[phase]));
                write_reg(CFG_ALPHA_MODE, STEP_W'(ext_am[phase]));
                write_reg(CFG_BAND_START, STEP_W'(ext_bs[phase]));
                write_reg(CFG_BAND_END, STEP_W'(ext_be[phase]));
                write_reg(CFG_STEP_EXPONENT, STEP_W'(ext_st[phase]));
            end
            else
            begin
                write_reg(CFG_INTEGRAL_MODE, STEP_W'($urandom_range(0, 1)));
                write_reg(CFG_ALPHA_MODE, STEP_W'($urandom_range(0, 3)));
                write_reg(CFG_BAND_START, STEP_W'($urandom_range(0, 64)));
                write_reg(CFG_BAND_END, STEP_W'($urandom_range(128, 256)));
                if ($urandom_range(0, 3) == 0)
                    write_reg(CFG_STEP_EXPONENT, STEP_W'($urandom_range(1, 1048575)));
                else
                    write_reg(CFG_STEP_EXPONENT, STEP_W'($urandom_range(1, 120000)));
            end
            no_gaps = ($urandom_range(0, 3) == 0);
            n       = ($urandom_range(0, 9) == 0 || phase == 2) ? 256 : $urandom_range(2, 24);
            for (int i = 0; i < n; i++)
            begin
                it              = random_word();
                it.cmd          = CMD_LOAD;
                it.sample_index = IDX_W'(i);
                it.sample_alpha = random_alpha();
                send_word(it, 0, none);
                idle_gap();
                if ($urandom_range(0, 19) == 0)
                begin
                    it              = random_word();
                    it.cmd          = CMD_LOAD;
                    it.sample_index = IDX_W'($urandom_range(0, i));
                    send_word(it, 0, none);
                    idle_gap();
                end
            end
            filled = n;
            nq     = $urandom_range(4, 20);
            for (int q = 0; q < nq; q++)
            begin
                it  = random_word();
                it.cmd = CMD_QUERY;
                f   = $urandom_range(0, filled - 1);
                if ($urandom_range(0, 29) == 0)
                begin
                    b = $urandom_range(0, filled - 1);
                end
                else
                begin
                    b = f + int'($urandom_range(0, 16)) - 8;
                    if (b < 0)
                        b = 0;
                    if (b > filled - 1)
                        b = filled - 1;
                end
                it.front_index = IDX_W'(f);
                it.back_index  = IDX_W'(b);
                send_word(it, 0, none);
                idle_gap();
            end
            drain();
            phase++;
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_colours.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
